>>> design/sida_pkg.sv
`timescale 1ns / 1ps

package sida_pkg;

  // ASCII codes used in a run
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Value and digit geometry
  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int MAX_DIGITS = 10;
  localparam int DIGITS_W   = DIGIT_W * MAX_DIGITS;
  localparam int NDIG_W     = 4;

  // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Entries in the queue between converter and emitter
  localparam int QUEUE_DEPTH = 2;

  // One converted value: sign, BCD digits (most significant in the top nibble)
  typedef struct packed {
    logic                negative;
    logic [DIGITS_W-1:0] digits;
    logic [NDIG_W-1:0]   ndig;
  } job_t;

endpackage

>>> design/sida_front.sv
`timescale 1ns / 1ps

module sida_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic signed [sida_pkg::VALUE_W-1:0] value,
  output logic                             job_valid,
  input  logic                             job_ready,
  output sida_pkg::job_t                   job
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DONE
  } state_t;

  state_t                              state;
  logic [sida_pkg::VALUE_W-1:0]        mag;
  logic                                negative;
  logic [sida_pkg::DIGITS_W-1:0]       digits;
  logic [sida_pkg::NDIG_W-1:0]         ndig;

  logic [sida_pkg::VALUE_W-1:0]        uval;
  logic [sida_pkg::VALUE_W-1:0]        mag_in;
  logic [2*sida_pkg::VALUE_W-1:0]      prod;
  logic [sida_pkg::VALUE_W-1:0]        quot;
  logic [sida_pkg::DIGIT_W-1:0]        ten_q_lo;
  logic [sida_pkg::DIGIT_W-1:0]        rem_digit;

  // Take the magnitude; the most negative value wraps to 2^31 as unsigned
  assign uval   = value;
  assign mag_in = uval[sida_pkg::VALUE_W-1] ? sida_pkg::VALUE_W'(~uval + 1'b1) : uval;

  // Divide by ten through the reciprocal; the remainder needs only four bits
  assign prod      = (2*sida_pkg::VALUE_W)'(mag) * (2*sida_pkg::VALUE_W)'(sida_pkg::RECIP10);
  assign quot      = sida_pkg::VALUE_W'(prod >> sida_pkg::RECIP_SHIFT);
  assign ten_q_lo  = 4'({quot[0], 3'b000}) + 4'({quot[2:0], 1'b0});
  assign rem_digit = mag[3:0] - ten_q_lo;

  assign full      = (state != ST_IDLE);
  assign job_valid = (state == ST_DONE);
  assign job       = '{negative: negative, digits: digits, ndig: ndig};

  // Accept, peel off one digit a cycle, hand the result over
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (push) begin
            negative <= uval[sida_pkg::VALUE_W-1];
            mag      <= mag_in;
            digits   <= '0;
            ndig     <= '0;
            state    <= ST_CONV;
          end
        end
        ST_CONV: begin
          digits <= {rem_digit, digits[sida_pkg::DIGITS_W-1:sida_pkg::DIGIT_W]};
          ndig   <= ndig + 1'b1;
          mag    <= quot;
          if (quot == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (job_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A 32-bit magnitude never needs more than ten digits
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (ndig < sida_pkg::NDIG_W'(sida_pkg::MAX_DIGITS)))
    else $error("front: digit count overrun");

  // A finished beat carries at least one digit
  assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job.ndig != '0))
    else $error("front: job without digits");
`endif

endmodule

>>> design/sida_queue.sv
`timescale 1ns / 1ps

module sida_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sida_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output sida_pkg::job_t out_job
);

  localparam int DEPTH = sida_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sida_pkg::job_t   slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_job   = slot[rd_ptr];
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  // Store an incoming beat
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wr_ptr] <= in_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // Occupancy never exceeds the number of slots
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue: occupancy overflow");
`endif

endmodule

>>> design/sida_back.sv
`timescale 1ns / 1ps

module sida_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  sida_pkg::job_t job,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     text_byte,
  output logic           last_byte
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DIGIT,
    PH_CR,
    PH_LF,
    PH_NUL
  } phase_t;

  localparam int TOP = sida_pkg::DIGITS_W - sida_pkg::DIGIT_W;

  phase_t                        phase;
  logic                          out_valid;
  logic [sida_pkg::DIGITS_W-1:0] digits;
  logic [sida_pkg::NDIG_W-1:0]   cnt;
  logic                          slot_free;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign job_ready = slot_free && (phase == PH_IDLE);

  // Emit one byte a cycle into the output register while it is free
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      if (slot_free) begin
        case (phase)
          PH_IDLE: begin
            if (job_valid) begin
              out_valid <= 1'b1;
              last_byte <= 1'b0;
              if (job.negative) begin
                text_byte <= sida_pkg::CH_MINUS;
                digits    <= job.digits;
                cnt       <= job.ndig;
                phase     <= PH_DIGIT;
              end else begin
                text_byte <= sida_pkg::CH_ZERO + 8'(job.digits[sida_pkg::DIGITS_W-1:TOP]);
                digits    <= job.digits << sida_pkg::DIGIT_W;
                cnt       <= job.ndig - 1'b1;
                phase     <= (job.ndig == sida_pkg::NDIG_W'(1)) ? PH_CR : PH_DIGIT;
              end
            end
          end
          PH_DIGIT: begin
            out_valid <= 1'b1;
            last_byte <= 1'b0;
            text_byte <= sida_pkg::CH_ZERO + 8'(digits[sida_pkg::DIGITS_W-1:TOP]);
            digits    <= digits << sida_pkg::DIGIT_W;
            cnt       <= cnt - 1'b1;
            phase     <= (cnt == sida_pkg::NDIG_W'(1)) ? PH_CR : PH_DIGIT;
          end
          PH_CR: begin
            out_valid <= 1'b1;
            last_byte <= 1'b0;
            text_byte <= sida_pkg::CH_CR;
            phase     <= PH_LF;
          end
          PH_LF: begin
            out_valid <= 1'b1;
            last_byte <= 1'b0;
            text_byte <= sida_pkg::CH_LF;
            phase     <= PH_NUL;
          end
          PH_NUL: begin
            out_valid <= 1'b1;
            last_byte <= 1'b1;
            text_byte <= sida_pkg::CH_NUL;
            phase     <= PH_IDLE;
          end
          default: begin
            phase <= PH_IDLE;
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // The closing flag only ever rides on the NUL terminator
  assert property (@(posedge clk) disable iff (rst)
    (!empty && last_byte) |-> (text_byte == sida_pkg::CH_NUL))
    else $error("back: last flag on a non-NUL byte");

  // Digits remain whenever the digit phase is entered
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DIGIT) |-> (cnt != '0))
    else $error("back: digit phase with no digits left");
`endif

endmodule

>>> design/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps

// Signed 32-bit integer to decimal ASCII text.
// Input channel: drive value and raise push; the value is taken at a clock
// edge where push is high and full is low. Output channel: while empty is
// low, text_byte/last_byte show the oldest byte; it is taken at an edge
// where pop is high. Each value gives a run of 4 to 14 bytes: an optional
// '-', the digits most significant first, then CR, LF and NUL, with
// last_byte high on the NUL.
// The converter produces one decimal digit per cycle (one divide by ten
// through a reciprocal multiplier) and takes a new value only after its
// result has gone into the queue; the emitter sends one byte per cycle
// while the output register is free. A two-entry queue sits between the
// two halves. Reset clears the queue, both sequencers and the output
// valid flag; empty goes high. When pop stays low the byte holds, the
// queue fills and full rises until the receiver drains it.
module signed_int_to_decimal_ascii_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [sida_pkg::VALUE_W-1:0] value,
  output logic                                empty,
  input  logic                                pop,
  output logic [7:0]                          text_byte,
  output logic                                last_byte
);

  logic           f_valid;
  logic           f_ready;
  sida_pkg::job_t f_job;
  logic           b_valid;
  logic           b_ready;
  sida_pkg::job_t b_job;

  sida_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  sida_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_job   (b_job)
  );

  sida_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .empty     (empty),
    .pop       (pop),
    .text_byte (text_byte),
    .last_byte (last_byte)
  );

endmodule
